/* rtl/core/rbd_pkg.sv */
// Shared types and codes for the ring buffer deque.
`timescale 1ns / 1ps
package rbd_pkg;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE       = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_PUSH_BACK  = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_HOLD      = 3'd0,
		CELL_SHIFT_UP  = 3'd1,
		CELL_SHIFT_DN  = 3'd2,
		CELL_APPEND    = 3'd3,
		CELL_DROP_LAST = 3'd4,
		CELL_CLEAR     = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     write_en;
	} cell_ctrl_t;

endpackage

/* rtl/core/rbd_if.sv */
// Valid/ready channel interfaces for deque commands and results.
`timescale 1ns / 1ps
interface rbd_cmd_if #(parameter int DATA_WIDTH = 32) ();
	logic                        valid;
	logic                        ready;
	logic [rbd_pkg::ACTION_W-1:0] action;
	logic [DATA_WIDTH-1:0]       push_value;

	modport source (output valid, action, push_value, input ready);
	modport sink (input valid, action, push_value, output ready);
endinterface

interface rbd_rsp_if #(parameter int DATA_WIDTH = 32, parameter int CNT_W = 5) ();
	logic                        valid;
	logic                        ready;
	logic [DATA_WIDTH-1:0]       popped_value;
	logic [rbd_pkg::STATUS_W-1:0] status;
	logic [CNT_W-1:0]            entry_count;
	logic                        is_empty;
	logic [DATA_WIDTH-1:0]       front_value;
	logic [DATA_WIDTH-1:0]       back_value;

	modport source (output valid, popped_value, status, entry_count, is_empty,
		front_value, back_value, input ready);
	modport sink (input valid, popped_value, status, entry_count, is_empty,
		front_value, back_value, output ready);
endinterface

/* rtl/core/ring_buffer_deque.sv */
// Deque of fixed capacity: a chain of word cells with the front at cell 0.
// An accepted command moves the state to S_CALC; its result is registered into the
// response registers from there once they are free. No new command is taken in
// S_CALC; there the back word comes from the chain via an AND-OR tree across all cells.
// A command is taken while an earlier result still waits to be read.
// Reset empties the deque at once by clearing the cell valid bits; no sweep.
`timescale 1ns / 1ps
module ring_buffer_deque #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	rbd_cmd_if.sink   cmd,
	rbd_rsp_if.source rsp
);
	import rbd_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CALC = 2'b10
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] popped_q;
	status_t               status_q;

	logic                  rsp_valid_q;
	logic [DATA_WIDTH-1:0] rsp_popped_q;
	status_t               rsp_status_q;
	logic [CNT_W-1:0]      rsp_count_q;
	logic                  rsp_empty_q;
	logic [DATA_WIDTH-1:0] rsp_front_q;
	logic [DATA_WIDTH-1:0] rsp_back_q;

	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  is_full;
	logic                  is_none;
	action_t               act;
	status_t               status_d;
	logic [DATA_WIDTH-1:0] popped_d;
	logic [CNT_W-1:0]      count_d;
	logic                  load_rsp;
	logic [DATA_WIDTH-1:0] back_w;

	logic                  cell_valid [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_tap   [CAPACITY];

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid & cmd.ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_none   = (count_q == '0);
	assign act       = action_t'(cmd.action);

	// Decode the command into one chain operation and the status it reports.
	always_comb begin
		ctrl.op       = CELL_HOLD;
		ctrl.write_en = accept;
		status_d      = STAT_OK;
		popped_d      = '0;
		count_d       = count_q;
		unique case (act) inside
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					ctrl.op = (act == ACT_PUSH_FRONT) ? CELL_SHIFT_UP : CELL_APPEND;
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (is_none) begin
					status_d = STAT_EMPTY;
				end else begin
					ctrl.op  = (act == ACT_POP_FRONT) ? CELL_SHIFT_DN : CELL_DROP_LAST;
					popped_d = (act == ACT_POP_FRONT) ? cell_data[0] : back_w;
					count_d  = count_q - CNT_W'(1);
				end
			end
			ACT_CLEAR: begin
				ctrl.op = CELL_CLEAR;
				count_d = '0;
			end
			default: begin
				ctrl.op = CELL_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  prev_valid;
		logic [DATA_WIDTH-1:0] prev_data;
		logic                  next_valid;
		logic [DATA_WIDTH-1:0] next_data;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_data  = cmd.push_value;
		end else begin : g_mid
			assign prev_valid = cell_valid[i-1];
			assign prev_data  = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign next_valid = 1'b0;
			assign next_data  = '0;
		end else begin : g_link
			assign next_valid = cell_valid[i+1];
			assign next_data  = cell_data[i+1];
		end

		rbd_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.push_value(cmd.push_value),
			.prev_valid(prev_valid),
			.prev_data (prev_data),
			.next_valid(next_valid),
			.next_data (next_data),
			.valid     (cell_valid[i]),
			.data      (cell_data[i]),
			.back_tap  (cell_tap[i])
		);
	end

	// At most one cell flags itself as last (none when empty), so the taps merge by OR.
	always_comb begin
		back_w = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_w = back_w | cell_tap[i];
		end
	end

	assign load_rsp = (state_q == S_CALC) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
						count_q <= count_d;
					end
				end
				S_CALC: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
		end
		if (load_rsp) begin
			rsp_popped_q <= popped_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= count_q;
			rsp_empty_q  <= ~cell_valid[0];
			rsp_front_q  <= cell_valid[0] ? cell_data[0] : '0;
			rsp_back_q   <= back_w;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_popped_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.entry_count  = rsp_count_q;
	assign rsp.is_empty     = rsp_empty_q;
	assign rsp.front_value  = rsp_front_q;
	assign rsp.back_value   = rsp_back_q;

endmodule

/* rtl/core/rbd_cell.sv */
// One storage cell of the deque chain, holding a single word and its occupancy.
`timescale 1ns / 1ps
module rbd_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbd_pkg::cell_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]  push_value,
	input  logic                   prev_valid,
	input  logic [DATA_WIDTH-1:0]  prev_data,
	input  logic                   next_valid,
	input  logic [DATA_WIDTH-1:0]  next_data,
	output logic                   valid,
	output logic [DATA_WIDTH-1:0]  data,
	output logic [DATA_WIDTH-1:0]  back_tap
);
	import rbd_pkg::*;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_last;
	logic                  valid_d;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  data_en;

	// This cell holds the back word when the chain ends right after it.
	assign is_last = valid_q & ~next_valid;

	always_comb begin
		valid_d = valid_q;
		data_d  = prev_data;
		data_en = 1'b0;
		if (ctrl.write_en) begin
			unique case (ctrl.op)
				CELL_SHIFT_UP: begin
					valid_d = prev_valid;
					data_d  = prev_data;
					data_en = 1'b1;
				end
				CELL_SHIFT_DN: begin
					valid_d = next_valid;
					data_d  = next_data;
					data_en = 1'b1;
				end
				CELL_APPEND: begin
					if (!valid_q && prev_valid) begin
						valid_d = 1'b1;
						data_d  = push_value;
						data_en = 1'b1;
					end
				end
				CELL_DROP_LAST: begin
					if (is_last) begin
						valid_d = 1'b0;
					end
				end
				CELL_CLEAR: begin
					valid_d = 1'b0;
				end
				default: begin
					valid_d = valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en) begin
			data_q <= data_d;
		end
	end

	assign valid    = valid_q;
	assign data     = data_q;
	assign back_tap = is_last ? data_q : '0;

endmodule
